// ----- sv/serial_flash_programmer_bridge_unit_defines.svh -----
// Assertion macros shared by the bridge RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef SERIAL_FLASH_PROGRAMMER_BRIDGE_UNIT_DEFINES_SVH
`define SERIAL_FLASH_PROGRAMMER_BRIDGE_UNIT_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define SFPB_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("sfpb: same-cycle check failed");

// Check that a condition implies another in the following cycle
`define SFPB_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("sfpb: next-cycle check failed");

`endif

// ----- sv/sfpb_pkg.sv -----
// Package for the serial flash programmer bridge: protocol codes, job type
// and reply tables. Used by the front end, queue, back end and top level.
`default_nettype none

package sfpb_pkg;

  // Length field width for SPI operations
  localparam int LEN_BITS = 24;

  // Protocol bytes
  localparam logic [7:0] ACK_CODE = 8'h06;
  localparam logic [7:0] NAK_CODE = 8'h15;
  localparam logic [7:0] BUS_SPI  = 8'h08;
  localparam logic [7:0] MAP_LOW  = 8'h3F;
  localparam logic [7:0] MAP_HIGH = 8'h0D;
  localparam int         MAP_PAD  = 29;
  localparam int         NAME_LEN = 16;

  // Host command codes
  localparam logic [7:0] CMD_NOP      = 8'h00;
  localparam logic [7:0] CMD_IFACE    = 8'h01;
  localparam logic [7:0] CMD_CMDMAP   = 8'h02;
  localparam logic [7:0] CMD_NAME     = 8'h03;
  localparam logic [7:0] CMD_BUFSIZE  = 8'h04;
  localparam logic [7:0] CMD_BUSTYPE  = 8'h05;
  localparam logic [7:0] CMD_SYNCNOP  = 8'h10;
  localparam logic [7:0] CMD_SETBUS   = 8'h12;
  localparam logic [7:0] CMD_SPI_OP   = 8'h13;

  // Item source
  localparam logic SRC_HOST = 1'b0;
  localparam logic SRC_SPI  = 1'b1;

  // Result targets
  localparam logic [1:0] TGT_HOST = 2'd0;
  localparam logic [1:0] TGT_SPI  = 2'd1;
  localparam logic [1:0] TGT_SEL  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_NAME_LOW  = 1'b0;
  localparam logic CFG_NAME_HIGH = 1'b1;

  // Queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Result counter width: covers the longest reply
  localparam int STEP_W = 6;

  // Fixed reply body that follows the first result
  typedef enum logic [2:0] {
    BODY_NONE,
    BODY_VERSION,
    BODY_MAP,
    BODY_NAME,
    BODY_BUFSIZE,
    BODY_BUSTYPE,
    BODY_SYNC
  } body_t;

  // Operation tail that follows the first result
  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_ACK_FINISH,
    TAIL_FINISH
  } tail_t;

  // One classified item, as handed from the front end to the back end
  typedef struct packed {
    logic [1:0] first_target;
    logic [7:0] first_byte;
    logic       first_level;
    body_t      body;
    tail_t      tail;
    logic       more_read;
  } job_t;

  // Number of body results
  function automatic logic [STEP_W-1:0] body_len(input body_t body);
    logic [STEP_W-1:0] len;
    unique case (body)
      BODY_VERSION: len = STEP_W'(2);
      BODY_MAP:     len = STEP_W'(3 + MAP_PAD);
      BODY_NAME:    len = STEP_W'(NAME_LEN);
      BODY_BUFSIZE: len = STEP_W'(2);
      BODY_BUSTYPE: len = STEP_W'(1);
      BODY_SYNC:    len = STEP_W'(1);
      default:      len = '0;
    endcase
    return len;
  endfunction

  // Number of tail results
  function automatic logic [STEP_W-1:0] tail_len(input tail_t tail);
    logic [STEP_W-1:0] len;
    unique case (tail)
      TAIL_ACK_FINISH: len = STEP_W'(2);
      TAIL_FINISH:     len = STEP_W'(1);
      default:         len = '0;
    endcase
    return len;
  endfunction

  // Fixed body bytes; the name body is taken from the registers elsewhere
  function automatic logic [7:0] body_byte(input body_t body, input logic [4:0] idx);
    logic [7:0] b;
    unique case (body)
      BODY_VERSION: b = (idx == 5'd0) ? 8'h01 : 8'h00;
      BODY_MAP: begin
        if (idx == 5'd0) b = MAP_LOW;
        else if (idx == 5'd2) b = MAP_HIGH;
        else b = 8'h00;
      end
      BODY_BUFSIZE: b = 8'hFF;
      BODY_BUSTYPE: b = BUS_SPI;
      BODY_SYNC:    b = ACK_CODE;
      default:      b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- sv/sfpb_front.sv -----
// Front end of the bridge: protocol state and item classification.
// Depends on sfpb_pkg; feeds classified jobs into sfpb_queue.
`default_nettype none

module sfpb_front
  import sfpb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic       cmd,
  input  wire logic [7:0] in_byte,
  output logic            push,
  output job_t            job
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_BUSARG = 3'd1;
  localparam logic [2:0] PH_HEADER = 3'd2;
  localparam logic [2:0] PH_WRITE  = 3'd3;
  localparam logic [2:0] PH_READ   = 3'd4;

  localparam logic [2:0] HDR_LAST    = 3'd5;
  localparam logic [2:0] HDR_RD_BASE = 3'd3;

  logic [2:0]          phase, phase_next;
  logic [2:0]          hdr_idx, hdr_idx_next;
  logic [LEN_BITS-1:0] wr_rem, wr_rem_next;
  logic [LEN_BITS-1:0] rd_rem, rd_rem_next;

  logic                has_job;
  logic [1:0]          len_sel;
  logic [23:0]         hdr_shift;
  logic [LEN_BITS-1:0] wr_dec;
  logic [LEN_BITS-1:0] rd_dec;
  logic [LEN_BITS-1:0] rd_hdr;

  // Place a header byte within its 24-bit length
  always_comb begin
    if (hdr_idx < HDR_RD_BASE) len_sel = hdr_idx[1:0];
    else len_sel = 2'(hdr_idx - HDR_RD_BASE);
    hdr_shift = {16'd0, in_byte} << {len_sel, 3'b000};
  end

  assign wr_dec = wr_rem - LEN_BITS'(1);
  assign rd_dec = rd_rem - LEN_BITS'(1);
  assign rd_hdr = rd_rem | hdr_shift[LEN_BITS-1:0];

  // Classify the item and work out the next protocol state
  always_comb begin
    phase_next   = phase;
    hdr_idx_next = hdr_idx;
    wr_rem_next  = wr_rem;
    rd_rem_next  = rd_rem;
    has_job      = 1'b0;
    job.first_target = TGT_HOST;
    job.first_byte   = ACK_CODE;
    job.first_level  = 1'b0;
    job.body         = BODY_NONE;
    job.tail         = TAIL_NONE;
    job.more_read    = 1'b0;

    if (cmd == SRC_HOST) begin
      unique case (phase)
        PH_IDLE: begin
          has_job = 1'b1;
          unique case (in_byte)
            CMD_NOP:     job.body = BODY_NONE;
            CMD_IFACE:   job.body = BODY_VERSION;
            CMD_CMDMAP:  job.body = BODY_MAP;
            CMD_NAME:    job.body = BODY_NAME;
            CMD_BUFSIZE: job.body = BODY_BUFSIZE;
            CMD_BUSTYPE: job.body = BODY_BUSTYPE;
            CMD_SYNCNOP: begin
              job.first_byte = NAK_CODE;
              job.body       = BODY_SYNC;
            end
            CMD_SETBUS: begin
              has_job    = 1'b0;
              phase_next = PH_BUSARG;
            end
            CMD_SPI_OP: begin
              has_job      = 1'b0;
              phase_next   = PH_HEADER;
              hdr_idx_next = 3'd0;
              wr_rem_next  = '0;
              rd_rem_next  = '0;
            end
            default: has_job = 1'b0;
          endcase
        end
        PH_BUSARG: begin
          has_job        = 1'b1;
          job.first_byte = (in_byte == BUS_SPI) ? ACK_CODE : NAK_CODE;
          phase_next     = PH_IDLE;
        end
        PH_HEADER: begin
          if (hdr_idx < HDR_RD_BASE) wr_rem_next = wr_rem | hdr_shift[LEN_BITS-1:0];
          else rd_rem_next = rd_hdr;
          if (hdr_idx != HDR_LAST) begin
            hdr_idx_next = hdr_idx + 3'd1;
          end else begin
            // Select the flash, then write or acknowledge at once
            hdr_idx_next     = 3'd0;
            has_job          = 1'b1;
            job.first_target = TGT_SEL;
            job.first_byte   = 8'h00;
            job.first_level  = 1'b1;
            job.more_read    = (rd_hdr != '0);
            if (wr_rem != '0) begin
              phase_next = PH_WRITE;
            end else begin
              job.tail   = TAIL_ACK_FINISH;
              phase_next = (rd_hdr != '0) ? PH_READ : PH_IDLE;
            end
          end
        end
        PH_WRITE: begin
          has_job          = 1'b1;
          job.first_target = TGT_SPI;
          job.first_byte   = in_byte;
          job.first_level  = 1'b1;
          job.more_read    = (rd_rem != '0);
          wr_rem_next      = wr_dec;
          if (wr_dec == '0) begin
            job.tail   = TAIL_ACK_FINISH;
            phase_next = (rd_rem != '0) ? PH_READ : PH_IDLE;
          end
        end
        default: has_job = 1'b0;
      endcase
    end else if (phase == PH_READ) begin
      // Return the read byte, then request more or release
      has_job          = 1'b1;
      job.first_target = TGT_HOST;
      job.first_byte   = in_byte;
      job.first_level  = 1'b1;
      job.tail         = TAIL_FINISH;
      job.more_read    = (rd_dec != '0);
      rd_rem_next      = rd_dec;
      if (rd_dec == '0) phase_next = PH_IDLE;
    end
  end

  assign push = accept && has_job;

  // Advance protocol state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      hdr_idx <= 3'd0;
      wr_rem  <= '0;
      rd_rem  <= '0;
    end else if (accept) begin
      phase   <= phase_next;
      hdr_idx <= hdr_idx_next;
      wr_rem  <= wr_rem_next;
      rd_rem  <= rd_rem_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/sfpb_queue.sv -----
// Short job queue between the front and back ends of the bridge.
// Depends on sfpb_pkg for the job type and depth.
`default_nettype none

module sfpb_queue
  import sfpb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head_job,
  output logic      empty,
  output logic      full
);

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign empty    = (count == '0);
  assign full     = (count == QCNT_W'(QDEPTH));
  assign head_job = slots[rd_ptr];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop) count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// ----- sv/sfpb_back.sv -----
// Back end of the bridge: expands each job into result items, one a cycle
// unless stalled, into an output register. Holds name regs; uses sfpb_pkg.
`default_nettype none

module sfpb_back
  import sfpb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire job_t        head_job,
  input  wire logic        empty,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       target,
  output logic [7:0]       out_byte,
  output logic             select_level,
  output logic             last
);

  logic [63:0]       name_low;
  logic [63:0]       name_high;
  logic [127:0]      name_word;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_m1;
  logic [STEP_W-1:0] total;
  logic              load;
  logic              res_last;
  logic [1:0]        res_target;
  logic [7:0]        res_byte;
  logic              res_level;

  // Write the name registers
  always_ff @(posedge clk) begin
    if (rst) begin
      name_low  <= '0;
      name_high <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_NAME_LOW) name_low <= cfg_data;
      else name_high <= cfg_data;
    end
  end

  assign name_word = {name_high, name_low};
  assign step_m1   = step - STEP_W'(1);
  assign total     = STEP_W'(1) + body_len(head_job.body) + tail_len(head_job.tail);
  assign res_last  = (step == total - STEP_W'(1));
  assign load      = !empty && (!out_valid || !out_stall);
  assign pop       = load && res_last;

  // Select the result for the current step of the head job
  always_comb begin
    res_target = TGT_HOST;
    res_byte   = 8'h00;
    res_level  = 1'b0;
    if (step == '0) begin
      res_target = head_job.first_target;
      res_byte   = head_job.first_byte;
      res_level  = head_job.first_level;
    end else if (head_job.body != BODY_NONE) begin
      if (head_job.body == BODY_NAME) res_byte = name_word[{step_m1[3:0], 3'b000} +: 8];
      else res_byte = body_byte(head_job.body, step_m1[4:0]);
    end else if (head_job.tail == TAIL_ACK_FINISH && !step_m1[0]) begin
      res_byte  = ACK_CODE;
      res_level = 1'b1;
    end else if (head_job.more_read) begin
      // Request the next read byte
      res_target = TGT_SPI;
      res_level  = 1'b1;
    end else begin
      // Release the flash
      res_target = TGT_SEL;
    end
  end

  // Advance through the job
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) step <= res_last ? '0 : step + STEP_W'(1);
      if (load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // Hold the result while stalled
  always_ff @(posedge clk) begin
    if (load) begin
      target       <= res_target;
      out_byte     <= res_byte;
      select_level <= res_level;
      last         <= res_last;
    end
  end

endmodule

`default_nettype wire

// ----- sv/serial_flash_programmer_bridge_unit.sv -----
// Throughput: one item accepted per cycle while the four-entry job queue has room;
// the back end gives one result per cycle unless stalled, one job at a time.
// Reset: synchronous, active high; clears protocol state, queue, out_valid and name registers.
// Top level of the bridge; depends on sfpb_pkg, sfpb_front, sfpb_queue, sfpb_back
// and the assertion macros header.
`default_nettype none
`include "serial_flash_programmer_bridge_unit_defines.svh"

module serial_flash_programmer_bridge_unit
  import sfpb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        cmd,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       target,
  output logic [7:0]       out_byte,
  output logic             select_level,
  output logic             last
);

  logic accept;
  logic q_push;
  logic q_pop;
  logic q_empty;
  logic q_full;
  job_t new_job;
  job_t head_job;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  sfpb_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .cmd     (cmd),
    .in_byte (in_byte),
    .push    (q_push),
    .job     (new_job)
  );

  sfpb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (new_job),
    .pop      (q_pop),
    .head_job (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  sfpb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .head_job     (head_job),
    .empty        (q_empty),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .target       (target),
    .out_byte     (out_byte),
    .select_level (select_level),
    .last         (last)
  );

  // Queue is never pushed when full or popped when empty
  `SFPB_ASSERT_IMP(a_push_room, clk, rst, q_push, !q_full)
  `SFPB_ASSERT_IMP(a_pop_data, clk, rst, q_pop, !q_empty)
  // Select changes carry a zero byte
  `SFPB_ASSERT_IMP(a_sel_zero, clk, rst, out_valid && (target == TGT_SEL), out_byte == 8'd0)
  // A release always closes the item's results
  `SFPB_ASSERT_IMP(a_release_last, clk, rst, out_valid && (target == TGT_SEL) && !select_level, last)

endmodule

`default_nettype wire
